[sv/spfq_pkg.sv]
// ----------------------------------------------------------------------------
// spfq_pkg
// shared constants, types and helpers of the strict priority fifo queue
// ----------------------------------------------------------------------------
`default_nettype none

package spfq_pkg;

  localparam int LEVELS      = 10;
  localparam int LEVEL_DEPTH = 16;
  localparam int ID_BITS     = 16;
  localparam int PRIO_W      = 4;

  localparam int LVL_W   = $clog2(LEVELS);
  localparam int SLOT_W  = $clog2(LEVEL_DEPTH);
  localparam int COUNT_W = $clog2(LEVEL_DEPTH + 1);
  localparam int ENTRIES = LEVELS * LEVEL_DEPTH;
  localparam int ADDR_W  = $clog2(ENTRIES);
  localparam int DATA_W  = ((ID_BITS + PRIO_W + 7) / 8) * 8;
  localparam int PAD_W   = DATA_W - ID_BITS - PRIO_W;

  localparam logic [PRIO_W:0]    LEVELS_EXT = (PRIO_W + 1)'(LEVELS);
  localparam logic [SLOT_W-1:0]  SLOT_LAST  = SLOT_W'(LEVEL_DEPTH - 1);
  localparam logic [COUNT_W-1:0] COUNT_FULL = COUNT_W'(LEVEL_DEPTH);
  localparam logic [ADDR_W-1:0]  DEPTH_A    = ADDR_W'(LEVEL_DEPTH);

  localparam logic MODE_ADD   = 1'b0;
  localparam logic MODE_SERVE = 1'b1;

  localparam logic STATUS_SERVED  = 1'b0;
  localparam logic STATUS_DROPPED = 1'b1;

  typedef struct packed {
    logic latch;
    logic exec;
    logic load;
  } spfq_cmd_t;

  typedef struct packed {
    logic serve;
    logic prio_ok;
    logic full;
    logic any_ready;
    logic out_busy;
  } spfq_sts_t;

  function automatic logic [ADDR_W-1:0] addr_of(input logic [LVL_W-1:0] lv,
                                                input logic [SLOT_W-1:0] slot);
    logic [ADDR_W-1:0] a;
    a = ADDR_W'(lv) * DEPTH_A + ADDR_W'(slot);
    return a;
  endfunction

  function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] p);
    logic [SLOT_W-1:0] n;
    n = (p == SLOT_LAST) ? '0 : p + SLOT_W'(1);
    return n;
  endfunction

endpackage

`default_nettype wire

[sv/spfq_ram.sv]
// ----------------------------------------------------------------------------
// spfq_ram
// generic single write port ram with registered read
// ----------------------------------------------------------------------------
`default_nettype none

module spfq_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 160
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[sv/spfq_ctrl.sv]
// ----------------------------------------------------------------------------
// spfq_ctrl
// sequencer: accept, execute, read out, hand result to the output register
// ----------------------------------------------------------------------------
`default_nettype none

module spfq_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire spfq_pkg::spfq_sts_t sts,
  output spfq_pkg::spfq_cmd_t    cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_READ,
    ST_HOLD
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready = (state == ST_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.latch  = 1'b1;
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd.exec = 1'b1;
        if (sts.serve) begin
          state_next = sts.any_ready ? ST_READ : ST_IDLE;
        end else if (sts.prio_ok && sts.full) begin
          if (sts.out_busy) begin
            state_next = ST_HOLD;
          end else begin
            cmd.load   = 1'b1;
            state_next = ST_IDLE;
          end
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_READ, ST_HOLD: begin
        if (!sts.out_busy) begin
          cmd.load   = 1'b1;
          state_next = ST_IDLE;
        end else begin
          state_next = ST_HOLD;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

[sv/spfq_datapath.sv]
// ----------------------------------------------------------------------------
// spfq_datapath
// per-level pointers and counts, entry ram, level pick and output register
// ----------------------------------------------------------------------------
`default_nettype none

module spfq_datapath (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire spfq_pkg::spfq_cmd_t             cmd,
  output spfq_pkg::spfq_sts_t                  sts,
  input  wire logic                            in_mode,
  input  wire logic [spfq_pkg::ID_BITS-1:0]    in_id,
  input  wire logic [spfq_pkg::PRIO_W-1:0]     in_prio,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic                                 out_status,
  output logic      [spfq_pkg::ID_BITS-1:0]    out_id,
  output logic      [spfq_pkg::PRIO_W-1:0]     out_prio
);

  logic                             mode_q;
  logic [spfq_pkg::ID_BITS-1:0]     id_q;
  logic [spfq_pkg::PRIO_W-1:0]      prio_q;
  logic [spfq_pkg::LVL_W-1:0]       srv_lv_q;

  logic [spfq_pkg::SLOT_W-1:0]      head  [spfq_pkg::LEVELS];
  logic [spfq_pkg::SLOT_W-1:0]      tail  [spfq_pkg::LEVELS];
  logic [spfq_pkg::COUNT_W-1:0]     count [spfq_pkg::LEVELS];

  logic                             prio_ok;
  logic [spfq_pkg::LVL_W-1:0]       add_lv;
  logic [spfq_pkg::LVL_W-1:0]       srv_lv;
  logic                             any_ready;
  logic                             full;
  logic                             do_add;
  logic                             do_serve;
  logic [spfq_pkg::ID_BITS-1:0]     ram_rdata;
  logic [spfq_pkg::PRIO_W-1:0]      prio_sub;

  assign prio_ok  = (prio_q != '0) && ({1'b0, prio_q} <= spfq_pkg::LEVELS_EXT);

  assign prio_sub = prio_q - spfq_pkg::PRIO_W'(1);
  assign add_lv   = prio_ok ? spfq_pkg::LVL_W'(prio_sub) : '0;
  assign full     = (count[add_lv] == spfq_pkg::COUNT_FULL);

  // lowest non-empty level wins
  always_comb begin
    srv_lv    = '0;
    any_ready = 1'b0;
    for (int i = spfq_pkg::LEVELS - 1; i >= 0; i--) begin
      if (count[i] != '0) begin
        srv_lv    = spfq_pkg::LVL_W'(i);
        any_ready = 1'b1;
      end
    end
  end

  assign do_add   = cmd.exec && (mode_q == spfq_pkg::MODE_ADD) && prio_ok && !full;
  assign do_serve = cmd.exec && (mode_q == spfq_pkg::MODE_SERVE) && any_ready;

  assign sts.serve     = (mode_q == spfq_pkg::MODE_SERVE);
  assign sts.prio_ok   = prio_ok;
  assign sts.full      = full;
  assign sts.any_ready = any_ready;
  assign sts.out_busy  = out_valid && !out_ready;

  spfq_ram #(
    .WIDTH (spfq_pkg::ID_BITS),
    .DEPTH (spfq_pkg::ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (do_add),
    .waddr (spfq_pkg::addr_of(add_lv, tail[add_lv])),
    .wdata (id_q),
    .re    (do_serve),
    .raddr (spfq_pkg::addr_of(srv_lv, head[srv_lv])),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      mode_q <= in_mode;
      id_q   <= in_id;
      prio_q <= in_prio;
    end
    if (do_serve) begin
      srv_lv_q <= srv_lv;
    end
    if (cmd.load) begin
      if (mode_q == spfq_pkg::MODE_ADD) begin
        out_status <= spfq_pkg::STATUS_DROPPED;
        out_id     <= id_q;
        out_prio   <= prio_q;
      end else begin
        out_status <= spfq_pkg::STATUS_SERVED;
        out_id     <= ram_rdata;
        out_prio   <= spfq_pkg::PRIO_W'(srv_lv_q) + spfq_pkg::PRIO_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      for (int i = 0; i < spfq_pkg::LEVELS; i++) begin
        head[i]  <= '0;
        tail[i]  <= '0;
        count[i] <= '0;
      end
    end else begin
      if (cmd.load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (do_add) begin
        tail[add_lv]  <= spfq_pkg::next_slot(tail[add_lv]);
        count[add_lv] <= count[add_lv] + spfq_pkg::COUNT_W'(1);
      end
      if (do_serve) begin
        head[srv_lv]  <= spfq_pkg::next_slot(head[srv_lv]);
        count[srv_lv] <= count[srv_lv] - spfq_pkg::COUNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

[sv/strict_priority_fifo_queue_core.sv]
// ----------------------------------------------------------------------------
// strict_priority_fifo_queue_core
// multi-level request queue, strict priority across levels, fifo within one
//
//   channel  dir  tuser               tdata
//   s_*      in   mode (0 add)        request_id, priority_req
//   m_*      out  status (1 dropped)  served_id, served_priority
//
// an add runs accept and execute, a serve with a result accept, execute and ram
// read, a serve on an empty queue accept and execute; the registered ram read adds
// the read state; a dropped add is loaded into the output register from execute,
// a served id from the read state; either waits in hold while that register is busy
// a result waits in the output register while the next item is accepted;
// a second result stalls the sequencer until m_tready frees that register
// reset clears pointers and counts; entry contents need no clearing
// ----------------------------------------------------------------------------
`default_nettype none

module strict_priority_fifo_queue_core (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          s_tvalid,
  output logic                               s_tready,
  input  wire logic [spfq_pkg::DATA_W-1:0]   s_tdata,  // request_id, priority_req, pad
  input  wire logic                          s_tuser,  // mode
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  output logic      [spfq_pkg::DATA_W-1:0]   m_tdata,  // served_id, served_priority, pad
  output logic                               m_tuser   // status
);

  spfq_pkg::spfq_cmd_t cmd;
  spfq_pkg::spfq_sts_t sts;

  logic [spfq_pkg::ID_BITS-1:0] out_id;
  logic [spfq_pkg::PRIO_W-1:0]  out_prio;

  spfq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  spfq_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .in_mode    (s_tuser),
    .in_id      (s_tdata[spfq_pkg::ID_BITS-1:0]),
    .in_prio    (s_tdata[spfq_pkg::ID_BITS +: spfq_pkg::PRIO_W]),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_status (m_tuser),
    .out_id     (out_id),
    .out_prio   (out_prio)
  );

  assign m_tdata = {{spfq_pkg::PAD_W{1'b0}}, out_prio, out_id};

endmodule

`default_nettype wire

[tb/spfq_result_checker.sv]
// ----------------------------------------------------------------------------
// spfq_result_checker
// watches both stream channels of the strict priority fifo queue, keeps its
// own copy of the per-level fifos, predicts each served or dropped id and
// compares every output transaction with the oldest prediction
// ----------------------------------------------------------------------------
module spfq_result_checker (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        s_tvalid,
  input  wire logic                        s_tready,
  input  wire logic [spfq_pkg::DATA_W-1:0] s_tdata,   // request_id, priority_req, pad
  input  wire logic                        s_tuser,   // mode
  input  wire logic                        m_tvalid,
  input  wire logic                        m_tready,
  input  wire logic [spfq_pkg::DATA_W-1:0] m_tdata,   // served_id, served_priority, pad
  input  wire logic                        m_tuser,   // status
  output int unsigned                      failures,
  output int unsigned                      outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned OWED_DEPTH = 16;

  typedef struct packed {
    logic                         status;
    logic [spfq_pkg::ID_BITS-1:0] id;
    logic [spfq_pkg::PRIO_W-1:0]  prio;
  } queue_result_t;

  logic [spfq_pkg::ID_BITS-1:0] held_ids [spfq_pkg::LEVELS][spfq_pkg::LEVEL_DEPTH];
  int unsigned                  head_slot [spfq_pkg::LEVELS];
  int unsigned                  tail_slot [spfq_pkg::LEVELS];
  int unsigned                  fill [spfq_pkg::LEVELS];
  queue_result_t                owed_results [OWED_DEPTH];
  int unsigned                  owed_wr  = 0;
  int unsigned                  owed_rd  = 0;
  int unsigned                  owed_cnt = 0;
  int unsigned                  fail_cnt = 0;

  initial begin
    failures    = 0;
    outstanding = 0;
  end

  task automatic report(input string what, input queue_result_t want,
                        input queue_result_t got);
    fail_cnt++;
    if (fail_cnt <= 10)
      $display("%0t mismatch (%s): expected status=%0d id=%h prio=%0d,",
               $realtime, what, want.status, want.id, want.prio,
               " got status=%0d id=%h prio=%0d", got.status, got.id, got.prio);
  endtask

  task automatic owe_result(input queue_result_t r);
    if (owed_cnt == OWED_DEPTH) begin
      report("too many pending results", r, '0);
    end else begin
      owed_results[owed_wr] = r;
      owed_wr = (owed_wr + 1) % OWED_DEPTH;
      owed_cnt++;
    end
  endtask

  task automatic apply_request(input logic mode, input logic [spfq_pkg::ID_BITS-1:0] id,
                               input logic [spfq_pkg::PRIO_W-1:0] prio);
    queue_result_t r;
    int unsigned   lv;
    if (mode == spfq_pkg::MODE_ADD) begin
      if (prio >= 1 && prio <= spfq_pkg::LEVELS) begin
        lv = prio - 1;
        if (fill[lv] == spfq_pkg::LEVEL_DEPTH) begin
          r.status = spfq_pkg::STATUS_DROPPED;
          r.id     = id;
          r.prio   = prio;
          owe_result(r);
        end else begin
          held_ids[lv][tail_slot[lv]] = id;
          tail_slot[lv] = (tail_slot[lv] + 1) % spfq_pkg::LEVEL_DEPTH;
          fill[lv]++;
        end
      end
    end else begin
      lv = 0;
      while (lv < spfq_pkg::LEVELS && fill[lv] == 0) lv++;
      if (lv < spfq_pkg::LEVELS) begin
        r.status = spfq_pkg::STATUS_SERVED;
        r.id     = held_ids[lv][head_slot[lv]];
        r.prio   = spfq_pkg::PRIO_W'(lv + 1);
        head_slot[lv] = (head_slot[lv] + 1) % spfq_pkg::LEVEL_DEPTH;
        fill[lv]--;
        owe_result(r);
      end
    end
  endtask

  task automatic check_result(input queue_result_t got);
    queue_result_t want;
    if (owed_cnt == 0) begin
      want = '0;
      report("unexpected result", want, got);
    end else begin
      want = owed_results[owed_rd];
      owed_rd = (owed_rd + 1) % OWED_DEPTH;
      owed_cnt--;
      if (got.status !== want.status || got.id !== want.id || got.prio !== want.prio)
        report("wrong field", want, got);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < spfq_pkg::LEVELS; i++) begin
        head_slot[i] = 0;
        tail_slot[i] = 0;
        fill[i]      = 0;
      end
      owed_wr  = 0;
      owed_rd  = 0;
      owed_cnt = 0;
    end else begin
      if (m_tvalid && m_tready)
        check_result({m_tuser, m_tdata[spfq_pkg::ID_BITS-1:0],
                      m_tdata[spfq_pkg::ID_BITS +: spfq_pkg::PRIO_W]});
      if (s_tvalid && s_tready)
        apply_request(s_tuser, s_tdata[spfq_pkg::ID_BITS-1:0],
                      s_tdata[spfq_pkg::ID_BITS +: spfq_pkg::PRIO_W]);
    end
    failures    <= fail_cnt;
    outstanding <= owed_cnt;
  end

endmodule

[tb/strict_priority_fifo_queue_core_tb.sv]
// ----------------------------------------------------------------------------
// strict_priority_fifo_queue_core_tb
// drives add and serve transactions into the queue with random gaps and
// receiver stalls, including one long receiver hold that backs up the input;
// the checker beside the block predicts and compares every result
// ----------------------------------------------------------------------------
module strict_priority_fifo_queue_core_tb ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RANDOM_ITEMS = 900;
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned HOLD_AT      = 300;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned DRAIN_CYCLES = 20;

  typedef enum int {ROUND_FILL, ROUND_MIX, ROUND_DRAIN, ROUND_NOISE} round_kind_t;

  logic                        clk = 1'b0;
  logic                        rst;
  logic                        s_tvalid;
  logic                        s_tready;
  logic [spfq_pkg::DATA_W-1:0] s_tdata;
  logic                        s_tuser;
  logic                        m_tvalid;
  logic                        m_tready;
  logic [spfq_pkg::DATA_W-1:0] m_tdata;
  logic                        m_tuser;
  int unsigned                 failures;
  int unsigned                 outstanding;

  logic        hold_req = 1'b0;
  logic        gapless  = 1'b0;
  int unsigned issued   = 0;

  always #1 clk = ~clk;

  strict_priority_fifo_queue_core u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  spfq_result_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser),
    .failures    (failures),
    .outstanding (outstanding)
  );

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // one input transaction, then an optional idle gap
  task automatic issue(input logic mode, input logic [spfq_pkg::ID_BITS-1:0] id,
                       input logic [spfq_pkg::PRIO_W-1:0] prio);
    int unsigned gap;
    s_tvalid <= 1'b1;
    s_tuser  <= mode;
    s_tdata  <= {{spfq_pkg::PAD_W{1'b0}}, prio, id};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if (mode == spfq_pkg::MODE_SERVE || (prio >= 1 && prio <= spfq_pkg::LEVELS)) begin
      issued++;
      if (issued == HOLD_AT) hold_req = 1'b1;
    end
    if (!gapless) begin
      gap = pick_gap();
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("simulation failed");
    $finish;
  end

  initial begin : sink
    int unsigned r;
    int unsigned run;
    m_tready = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        r = $urandom_range(0, 99);
        if (r < 50) begin
          m_tready <= 1'b1;
          run = $urandom_range(1, 24);
        end else if (r < 60) begin
          m_tready <= 1'b1;
          run = $urandom_range(100, 300);
        end else if (r < 92) begin
          m_tready <= 1'b0;
          run = $urandom_range(1, 3);
        end else begin
          m_tready <= 1'b0;
          run = $urandom_range(8, 40);
        end
        repeat (run) @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    round_kind_t                 kind;
    int unsigned                 len;
    int unsigned                 lo;
    int unsigned                 hi;
    logic                        serve;
    logic [spfq_pkg::PRIO_W-1:0] prio;
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tuser  = spfq_pkg::MODE_ADD;
    s_tdata  = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // extremes, ignored levels and serves on an empty queue
    issue(spfq_pkg::MODE_SERVE, 16'h0000, 4'd0);
    issue(spfq_pkg::MODE_ADD,   16'h0000, 4'd1);
    issue(spfq_pkg::MODE_ADD,   16'hFFFF, 4'd10);
    issue(spfq_pkg::MODE_ADD,   16'h1234, 4'd0);
    issue(spfq_pkg::MODE_ADD,   16'hABCD, 4'd11);
    issue(spfq_pkg::MODE_ADD,   16'h5A5A, 4'd15);
    issue(spfq_pkg::MODE_ADD,   16'hA5A5, 4'd5);
    issue(spfq_pkg::MODE_SERVE, 16'hFFFF, 4'd15);
    issue(spfq_pkg::MODE_SERVE, 16'h0000, 4'd0);
    issue(spfq_pkg::MODE_SERVE, 16'h7777, 4'd7);
    issue(spfq_pkg::MODE_SERVE, 16'hFFFF, 4'd10);
    issued = 0;

    while (issued < RANDOM_ITEMS) begin
      kind    = round_kind_t'($urandom_range(0, 3));
      len     = $urandom_range(10, 40);
      gapless = ($urandom_range(0, 3) == 0);
      lo      = $urandom_range(1, spfq_pkg::LEVELS);
      hi      = (lo < spfq_pkg::LEVELS) ? lo + $urandom_range(0, 1) : lo;
      for (int i = 0; i < len && issued < RANDOM_ITEMS; i++) begin
        case (kind)
          ROUND_FILL: begin
            serve = ($urandom_range(0, 9) == 0);
            prio  = spfq_pkg::PRIO_W'($urandom_range(lo, hi));
          end
          ROUND_MIX: begin
            serve = 1'($urandom_range(0, 1));
            prio  = spfq_pkg::PRIO_W'($urandom_range(1, spfq_pkg::LEVELS));
          end
          ROUND_DRAIN: begin
            serve = ($urandom_range(0, 4) != 0);
            prio  = spfq_pkg::PRIO_W'($urandom_range(1, spfq_pkg::LEVELS));
          end
          default: begin
            serve = ($urandom_range(0, 2) == 0);
            prio  = spfq_pkg::PRIO_W'($urandom_range(0, 15));
          end
        endcase
        issue(serve ? spfq_pkg::MODE_SERVE : spfq_pkg::MODE_ADD,
              spfq_pkg::ID_BITS'($urandom_range(0, 16'hFFFF)), prio);
      end
    end
    gapless  = 1'b0;
    s_tvalid <= 1'b0;

    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (failures == 0 && outstanding == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
